// File: src/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SGI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgi assertion failed");

// Next-cycle implication, checked outside reset.
`define SGI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgi assertion failed");

`endif

// File: src/sgi_pkg.sv
package sgi_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int REG_WIDTH       = 32;
  localparam int NUM_REGS        = 2;

  localparam int DW    = COORD_WIDTH + 1;        // coordinate difference
  localparam int H     = (DW > 16) ? DW : 16;    // half operand for wide products
  localparam int MW    = H + 1;                  // signed multiplier operand
  localparam int PW    = 2 * MW;                 // multiplier product
  localparam int SQW   = 2 * DW;                 // d2, len2, |perp|
  localparam int DOTW  = 2 * DW + 1;             // signed dot and perp
  localparam int NUMW  = REG_WIDTH + 2 * H;      // C * len2
  localparam int DENW  = 4 * H + 1;              // perp^2 + z * len2
  localparam int REMW  = DENW + 1;
  localparam int LW    = LEVEL_FRAC_BITS + 1;    // level incl. 1.0
  localparam int CNTW  = $clog2(LEVEL_FRAC_BITS);
  localparam int NSTEP = 22;
  localparam int STW   = $clog2(NSTEP);
  localparam int IDXW  = $clog2(NUM_REGS);

  localparam logic [IDXW-1:0] REG_LIGHT_STRENGTH = IDXW'(0);
  localparam logic [IDXW-1:0] REG_HEIGHT_SQ      = IDXW'(1);
  localparam logic [REG_WIDTH-1:0] REG_RESET_VAL = REG_WIDTH'(256);
  localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRAC_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LW-1:0] level_t;

endpackage

// File: src/segment_glow_intensity_top.sv
// channel  | handshake         | payload
// cfg      | cfg_write         | cfg_index, cfg_data
// in       | in_valid/in_stall | pixel_x..end_y, last_segment
// out      | out_valid/out_stall | light_level, saturated
// A request passes accept and set-up, 22 multiplier steps and a drain, then per
// term (two points, one line) set-up, check and 16 divider steps, then emit.
// A capped term skips the divider; a masked line term stops at set-up.
// rst is synchronous: control and running maximum clear, both registers reset to 256.
// in_stall is high while a request is in work; the output register lets a
// result wait on out_stall while the next request is taken.
module segment_glow_intensity_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sgi_pkg::IDXW-1:0]        cfg_index,
  input  logic [sgi_pkg::REG_WIDTH-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sgi_pkg::coord_t                 pixel_x,
  input  sgi_pkg::coord_t                 pixel_y,
  input  sgi_pkg::coord_t                 start_x,
  input  sgi_pkg::coord_t                 start_y,
  input  sgi_pkg::coord_t                 end_x,
  input  sgi_pkg::coord_t                 end_y,
  input  logic                            last_segment,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sgi_pkg::level_t                 light_level,
  output logic                            saturated
);
  import sgi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_DRAIN, S_SETUP, S_CHECK, S_DIV, S_EMIT
  } state_t;

  state_t state;

  logic [REG_WIDTH-1:0] light_strength, height_sq;
  coord_t px, py, sx, sy, ex, ey;
  logic last;

  logic signed [DW-1:0] wx, wy, dx2, dy2, vx, vy;
  logic [SQW-1:0] len2, d2a, d2b;
  logic signed [DOTW-1:0] dot, perp;
  logic [NUMW-1:0] lnum;
  logic [DENW-1:0] lden;

  logic [STW-1:0] step, step_d;
  logic mv;
  logic signed [PW-1:0] prod;

  logic [1:0] term;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;
  logic [REMW-1:0] rem;
  logic [LEVEL_FRAC_BITS-1:0] q;
  logic [CNTW-1:0] cnt;

  level_t running_max;
  logic sat_seen;

  // operand selection for the shared multiplier
  logic signed [MW-1:0] op_a, op_b;
  logic [2*H-1:0] len2x, pmx, cx, zx;
  logic [SQW-1:0] pm;
  logic [SQW-1:0] perp_abs;
  logic win;
  logic [REMW-1:0] rem2;
  logic rem_ge;
  logic emit_go;

  assign perp_abs = perp[DOTW-1] ? SQW'(-perp) : SQW'(perp);
  assign pm    = perp_abs;
  assign len2x = (2*H)'(len2);
  assign pmx   = (2*H)'(pm);
  assign cx    = (2*H)'(light_strength);
  assign zx    = (2*H)'(height_sq);
  assign win   = !dot[DOTW-1] && (dot != '0) && (dot[DOTW-2:0] < len2);
  assign rem2  = {rem[REMW-2:0], 1'b0};
  assign rem_ge = rem2 >= REMW'(den_r);
  assign emit_go = (state == S_EMIT) && last && (!out_valid || !out_stall);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      STW'(0):  begin op_a = MW'(vx);  op_b = MW'(vx);  end
      STW'(1):  begin op_a = MW'(vy);  op_b = MW'(vy);  end
      STW'(2):  begin op_a = MW'(wy);  op_b = MW'(vx);  end
      STW'(3):  begin op_a = MW'(wx);  op_b = MW'(vy);  end
      STW'(4):  begin op_a = MW'(wx);  op_b = MW'(vx);  end
      STW'(5):  begin op_a = MW'(wy);  op_b = MW'(vy);  end
      STW'(6):  begin op_a = MW'(wx);  op_b = MW'(wx);  end
      STW'(7):  begin op_a = MW'(wy);  op_b = MW'(wy);  end
      STW'(8):  begin op_a = MW'(dx2); op_b = MW'(dx2); end
      STW'(9):  begin op_a = MW'(dy2); op_b = MW'(dy2); end
      STW'(10): begin op_a = {1'b0, cx[H-1:0]};   op_b = {1'b0, len2x[H-1:0]};   end
      STW'(11): begin op_a = {1'b0, cx[H-1:0]};   op_b = {1'b0, len2x[2*H-1:H]}; end
      STW'(12): begin op_a = {1'b0, cx[2*H-1:H]}; op_b = {1'b0, len2x[H-1:0]};   end
      STW'(13): begin op_a = {1'b0, cx[2*H-1:H]}; op_b = {1'b0, len2x[2*H-1:H]}; end
      STW'(14): begin op_a = {1'b0, pmx[H-1:0]};  op_b = {1'b0, pmx[H-1:0]};     end
      STW'(15): begin op_a = {1'b0, pmx[H-1:0]};  op_b = {1'b0, pmx[2*H-1:H]};   end
      STW'(16): begin op_a = {1'b0, pmx[2*H-1:H]}; op_b = {1'b0, pmx[H-1:0]};    end
      STW'(17): begin op_a = {1'b0, pmx[2*H-1:H]}; op_b = {1'b0, pmx[2*H-1:H]};  end
      STW'(18): begin op_a = {1'b0, zx[H-1:0]};   op_b = {1'b0, len2x[H-1:0]};   end
      STW'(19): begin op_a = {1'b0, zx[H-1:0]};   op_b = {1'b0, len2x[2*H-1:H]}; end
      STW'(20): begin op_a = {1'b0, zx[2*H-1:H]}; op_b = {1'b0, len2x[H-1:0]};   end
      STW'(21): begin op_a = {1'b0, zx[2*H-1:H]}; op_b = {1'b0, len2x[2*H-1:H]}; end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    prod   <= op_a * op_b;
    step_d <= step;

    if (rst) begin
      state          <= S_IDLE;
      light_strength <= REG_RESET_VAL;
      height_sq      <= REG_RESET_VAL;
      running_max    <= '0;
      sat_seen       <= 1'b0;
      out_valid      <= 1'b0;
      mv             <= 1'b0;
      step           <= '0;
      term           <= '0;
      cnt            <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_LIGHT_STRENGTH: light_strength <= cfg_data;
          REG_HEIGHT_SQ:      height_sq      <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !emit_go) out_valid <= 1'b0;

      mv <= (state == S_MUL);
      if (mv) begin
        case (step_d)
          STW'(0), STW'(1): len2 <= len2 + SQW'(prod);
          STW'(2):          perp <= perp + DOTW'(prod);
          STW'(3):          perp <= perp - DOTW'(prod);
          STW'(4), STW'(5): dot  <= dot + DOTW'(prod);
          STW'(6), STW'(7): d2a  <= d2a + SQW'(prod);
          STW'(8), STW'(9): d2b  <= d2b + SQW'(prod);
          STW'(10):         lnum <= lnum + NUMW'($unsigned(prod));
          STW'(11), STW'(12): lnum <= lnum + (NUMW'($unsigned(prod)) << H);
          STW'(13):         lnum <= lnum + (NUMW'($unsigned(prod)) << (2*H));
          STW'(14), STW'(18): lden <= lden + DENW'($unsigned(prod));
          STW'(15), STW'(16), STW'(19), STW'(20):
                            lden <= lden + (DENW'($unsigned(prod)) << H);
          STW'(17), STW'(21): lden <= lden + (DENW'($unsigned(prod)) << (2*H));
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            px <= pixel_x; py <= pixel_y;
            sx <= start_x; sy <= start_y;
            ex <= end_x;   ey <= end_y;
            last  <= last_segment;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          wx  <= DW'(px) - DW'(sx);
          wy  <= DW'(py) - DW'(sy);
          dx2 <= DW'(px) - DW'(ex);
          dy2 <= DW'(py) - DW'(ey);
          vx  <= DW'(ex) - DW'(sx);
          vy  <= DW'(ey) - DW'(sy);
          len2 <= '0; perp <= '0; dot <= '0;
          d2a  <= '0; d2b  <= '0; lnum <= '0; lden <= '0;
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (step == STW'(NSTEP - 1)) state <= S_DRAIN;
          else step <= step + STW'(1);
        end
        S_DRAIN: begin
          term  <= '0;
          state <= S_SETUP;
        end
        S_SETUP: begin
          case (term)
            2'd0: begin
              num_r <= NUMW'(light_strength);
              den_r <= DENW'(d2a) + DENW'(height_sq);
            end
            2'd1: begin
              num_r <= NUMW'(light_strength);
              den_r <= DENW'(d2b) + DENW'(height_sq);
            end
            default: begin
              num_r <= lnum;
              den_r <= lden;
            end
          endcase
          // line term outside the projection window is dropped
          if (term == 2'd2 && !win) state <= S_EMIT;
          else state <= S_CHECK;
        end
        S_CHECK: begin
          if (den_r == '0 || DENW'(num_r) >= den_r) begin
            if (LEVEL_ONE > running_max) running_max <= LEVEL_ONE;
            sat_seen <= 1'b1;
            term  <= term + 2'd1;
            state <= (term == 2'd2) ? S_EMIT : S_SETUP;
          end else begin
            rem   <= REMW'(num_r);
            q     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) rem <= rem2 - REMW'(den_r);
          else        rem <= rem2;
          q   <= {q[LEVEL_FRAC_BITS-2:0], rem_ge};
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(LEVEL_FRAC_BITS - 1)) begin
            if (LW'({q[LEVEL_FRAC_BITS-2:0], rem_ge}) > running_max)
              running_max <= LW'({q[LEVEL_FRAC_BITS-2:0], rem_ge});
            term  <= term + 2'd1;
            state <= (term == 2'd2) ? S_EMIT : S_SETUP;
          end
        end
        S_EMIT: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (emit_go) begin
            out_valid   <= 1'b1;
            light_level <= running_max;
            saturated   <= sat_seen;
            running_max <= '0;
            sat_seen    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/sgi_checker.sv
`include "assert_macros.svh"

module sgi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sgi_pkg::LW-1:0]        light_level,
  input logic                          saturated
);
  import sgi_pkg::*;

  // a held result is not dropped
  `SGI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  // a taken request keeps the input side busy
  `SGI_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // level never exceeds 1.0
  `SGI_ASSERT_IMP(a_level_cap, out_valid, light_level <= LEVEL_ONE)
  // a full 1.0 level only comes from the cap, which flags saturation
  `SGI_ASSERT_IMP(a_one_sat, out_valid && light_level == LEVEL_ONE, saturated)

endmodule

bind segment_glow_intensity_top sgi_checker u_sgi_checker (.*);
